@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk, switched off while rst_n is low.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge of clk, reset cycles included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/mfnm_pkg.sv @@
package mfnm_pkg;

    localparam int MAX_WIDTH = 256;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ADDR_W    = COL_W + 1;
    localparam int ROW_WIDTH_W = 9;
    localparam int CMP_W     = (ROW_WIDTH_W > COL_W + 1) ? ROW_WIDTH_W : COL_W + 1;
    localparam int CHAN_W    = 8;
    localparam int NUM_CHAN  = 3;
    localparam int PIX_W     = NUM_CHAN * CHAN_W;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = ROW_WIDTH_W;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RED_LOW    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RED_HIGH   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_GREEN_LOW  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_GREEN_HIGH = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BLUE_LOW   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_BLUE_HIGH  = 3'd6;

    // Reset values.
    localparam logic [ROW_WIDTH_W-1:0] RST_ROW_WIDTH = 9'd256;
    localparam logic [CHAN_W-1:0] RST_RED_LOW    = 8'd70;
    localparam logic [CHAN_W-1:0] RST_RED_HIGH   = 8'd255;
    localparam logic [CHAN_W-1:0] RST_GREEN_LOW  = 8'd20;
    localparam logic [CHAN_W-1:0] RST_GREEN_HIGH = 8'd205;
    localparam logic [CHAN_W-1:0] RST_BLUE_LOW   = 8'd0;
    localparam logic [CHAN_W-1:0] RST_BLUE_HIGH  = 8'd190;

    // Input command carried in tuser.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

endpackage

@@ src/mirrored_film_negative_map.sv @@
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+---------------------------------------------
// s_       | in        | s_tvalid/s_tready  | tdata: red, green, blue; tuser: cmd
// m_       | out       | m_tvalid/m_tready  | tdata: red, green, blue; tlast: row_end
// cfg_     | in        | cfg_wr_en          | cfg_addr: register index, cfg_wdata: value
//
// One beat per cycle each way unless m_ stalls; results pass three register stages.
// The first stage is the single row memory: one write and one registered read per beat.
// The mapping takes two more register stages: channel products, then the sum divided by 255.
// Reset is synchronous and clears control state only; the row memory is not cleared.
// A stall on m_ backs up through the three stages before s_tready drops.
module mirrored_film_negative_map (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [mfnm_pkg::PIX_W-1:0]             s_tdata,  // red_in, green_in, blue_in
    input  logic                                   s_tuser,  // cmd
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [mfnm_pkg::PIX_W-1:0]             m_tdata,  // red_out, green_out, blue_out
    output logic                                   m_tlast,
    input  logic                                   cfg_wr_en,
    input  logic [mfnm_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [mfnm_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    localparam int COL_W  = mfnm_pkg::COL_W;
    localparam int ADDR_W = mfnm_pkg::ADDR_W;
    localparam int CMP_W  = mfnm_pkg::CMP_W;
    localparam int CHAN_W = mfnm_pkg::CHAN_W;
    localparam int NCH    = mfnm_pkg::NUM_CHAN;
    localparam int PIX_W  = mfnm_pkg::PIX_W;
    localparam int PROD_W = 2 * CHAN_W;

    // Configuration registers.
    logic [mfnm_pkg::ROW_WIDTH_W-1:0] row_width_reg;
    logic [CHAN_W-1:0] chan_low_reg  [NCH];
    logic [CHAN_W-1:0] chan_high_reg [NCH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg    <= mfnm_pkg::RST_ROW_WIDTH;
            chan_low_reg[0]  <= mfnm_pkg::RST_RED_LOW;
            chan_high_reg[0] <= mfnm_pkg::RST_RED_HIGH;
            chan_low_reg[1]  <= mfnm_pkg::RST_GREEN_LOW;
            chan_high_reg[1] <= mfnm_pkg::RST_GREEN_HIGH;
            chan_low_reg[2]  <= mfnm_pkg::RST_BLUE_LOW;
            chan_high_reg[2] <= mfnm_pkg::RST_BLUE_HIGH;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                mfnm_pkg::REG_ROW_WIDTH:  row_width_reg    <= cfg_wdata;
                mfnm_pkg::REG_RED_LOW:    chan_low_reg[0]  <= cfg_wdata[CHAN_W-1:0];
                mfnm_pkg::REG_RED_HIGH:   chan_high_reg[0] <= cfg_wdata[CHAN_W-1:0];
                mfnm_pkg::REG_GREEN_LOW:  chan_low_reg[1]  <= cfg_wdata[CHAN_W-1:0];
                mfnm_pkg::REG_GREEN_HIGH: chan_high_reg[1] <= cfg_wdata[CHAN_W-1:0];
                mfnm_pkg::REG_BLUE_LOW:   chan_low_reg[2]  <= cfg_wdata[CHAN_W-1:0];
                mfnm_pkg::REG_BLUE_HIGH:  chan_high_reg[2] <= cfg_wdata[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // Row control state.
    logic [COL_W-1:0] column_reg;
    logic             write_bank_reg;
    logic             prev_ready_reg;
    logic             draining_reg;

    // Pipeline valids and ready chain.
    logic v1_reg, v2_reg, m_tvalid_reg;
    logic rdy1, rdy2, rdy3;
    logic accept;

    assign rdy3     = !m_tvalid_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign accept   = s_tvalid && rdy1;

    // Effective width and read position.
    logic [CMP_W-1:0] rw_ext, eff_w, col_ext;
    logic [COL_W-1:0] rd_col;
    logic             last;
    logic             drain;

    always_comb begin
        rw_ext  = CMP_W'(row_width_reg);
        col_ext = CMP_W'(column_reg);
        if (rw_ext == '0) begin
            eff_w = CMP_W'(1);
        end else if (rw_ext > CMP_W'(mfnm_pkg::MAX_WIDTH)) begin
            eff_w = CMP_W'(mfnm_pkg::MAX_WIDTH);
        end else begin
            eff_w = rw_ext;
        end
        last = (col_ext + CMP_W'(1)) >= eff_w;
        // A column left beyond a shrunken width reads position zero.
        if (col_ext < eff_w) begin
            rd_col = COL_W'(eff_w - CMP_W'(1) - col_ext);
        end else begin
            rd_col = '0;
        end
        drain = (s_tuser == mfnm_pkg::CMD_DRAIN);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg     <= '0;
            write_bank_reg <= 1'b0;
            prev_ready_reg <= 1'b0;
            draining_reg   <= 1'b0;
        end else if (accept) begin
            if (drain && !prev_ready_reg) begin
                column_reg   <= '0;
                draining_reg <= 1'b0;
            end else if (last) begin
                column_reg <= '0;
                // A drain anywhere in the row drops it instead of swapping banks.
                if (draining_reg || drain) begin
                    prev_ready_reg <= 1'b0;
                    draining_reg   <= 1'b0;
                end else begin
                    write_bank_reg <= !write_bank_reg;
                    prev_ready_reg <= 1'b1;
                end
            end else begin
                column_reg <= column_reg + COL_W'(1);
                if (drain) begin
                    draining_reg <= 1'b1;
                end
            end
        end
    end

    // Ping-pong row memory: the two banks are never the same, so a read and a
    // write in one cycle cannot meet on one entry.
    logic [PIX_W-1:0] row_mem [2**ADDR_W];
    logic [PIX_W-1:0] pix_reg;
    logic             last1_reg;

    always_ff @(posedge aclk) begin
        if (accept && !drain) begin
            row_mem[{write_bank_reg, column_reg}] <= s_tdata;
        end
        if (accept) begin
            pix_reg   <= row_mem[{!write_bank_reg, rd_col}];
            last1_reg <= last;
        end
    end

    // Stage 2: low*v and high*(255-v) for each channel.
    logic [PROD_W-1:0] prod_lo_reg [NCH];
    logic [PROD_W-1:0] prod_hi_reg [NCH];
    logic              last2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            for (int c = 0; c < NCH; c++) begin
                prod_lo_reg[c] <= PROD_W'(chan_low_reg[c])
                                * PROD_W'(pix_reg[c*CHAN_W +: CHAN_W]);
                // The inversion is taken at sample width so that it gives 255 - v.
                prod_hi_reg[c] <= PROD_W'(chan_high_reg[c])
                                * PROD_W'(CHAN_W'(~pix_reg[c*CHAN_W +: CHAN_W]));
            end
            last2_reg <= last1_reg;
        end
    end

    // Stage 3: floor(n / 255) as (n + 1 + (n >> 8)) >> 8, exact for n up to 65025.
    logic [PROD_W-1:0] num  [NCH];
    logic [PROD_W-1:0] quot [NCH];

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            num[c]  = prod_lo_reg[c] + prod_hi_reg[c];
            quot[c] = num[c] + PROD_W'(1) + PROD_W'(num[c][PROD_W-1:CHAN_W]);
        end
    end

    logic [PIX_W-1:0] m_tdata_reg;
    logic             m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            for (int c = 0; c < NCH; c++) begin
                m_tdata_reg[c*CHAN_W +: CHAN_W] <= quot[c][PROD_W-1:CHAN_W];
            end
            m_tlast_reg <= last2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= accept && prev_ready_reg;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                m_tvalid_reg <= v2_reg;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ src/mfnm_checker.sv @@
`include "assert_macros.svh"

module mfnm_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [mfnm_pkg::PIX_W-1:0]  m_tdata,
    input logic                        m_tlast
);

    logic                       m_stall;
    logic                       s_block;
    logic [mfnm_pkg::PIX_W:0]   m_beat;

    assign m_stall = m_tvalid && !m_tready;
    assign s_block = !s_tready && !m_tready;
    assign m_beat  = {m_tlast, m_tdata};

    // The result side must be empty straight after reset.
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "valid after reset")

    // The input side only pushes back once a result is waiting at the output.
    `ASSERT_CLKD(a_backpressure_source, aclk, aresetn, !s_tready |-> m_tvalid, "ready low, empty")

    // With every stage full and the output stalled, the input follows m_tready next cycle.
    `ASSERT_CLKD(a_hold_block, aclk, aresetn, s_block |=> (s_tready == m_tready), "early release")

    // A stalled result stays presented.
    `ASSERT_CLKD(a_valid_hold, aclk, aresetn, m_stall |=> m_tvalid, "m_tvalid dropped in a stall")

    // A stalled result keeps its payload.
    `ASSERT_CLKD(a_data_hold, aclk, aresetn, m_stall |=> $stable(m_beat), "payload moved")

endmodule

bind mirrored_film_negative_map mfnm_checker u_mfnm_checker (.*);

@@ sim/mirrored_film_negative_map_tb.sv @@
module mirrored_film_negative_map_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHAN_W      = mfnm_pkg::CHAN_W;
    localparam int PIX_W       = mfnm_pkg::PIX_W;
    localparam int NUM_CHAN    = mfnm_pkg::NUM_CHAN;
    localparam int MAX_WIDTH   = mfnm_pkg::MAX_WIDTH;
    localparam int ROW_WIDTH_W = mfnm_pkg::ROW_WIDTH_W;
    localparam int CFG_ADDR_W  = mfnm_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W  = mfnm_pkg::CFG_DATA_W;

    localparam int ITEM_TARGET    = 1550;
    localparam int QUIET_LIMIT    = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_PRINTED    = 50;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              row_end;
    } mapped_px_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata   = '0;  // red_in, green_in, blue_in
    logic                  s_tuser   = mfnm_pkg::CMD_PIXEL;  // cmd
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [PIX_W-1:0]      m_tdata;  // red_out, green_out, blue_out
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = mfnm_pkg::REG_ROW_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Shadow of the block: row memory, position, banks and the register file.
    logic [PIX_W-1:0]       row_mem [2*MAX_WIDTH];
    int                     col_pos;
    logic                   wr_bank;
    logic                   prior_row_ok;
    logic                   row_dropped;
    logic [ROW_WIDTH_W-1:0] width_reg;
    logic [CHAN_W-1:0]      lo_lvl [NUM_CHAN];
    logic [CHAN_W-1:0]      hi_lvl [NUM_CHAN];

    mapped_px_t mapped_pixels_due [$];
    int         beats_sent     = 0;
    int         error_count    = 0;
    int         quiet_cycles   = 0;
    int         src_gap_lim    = 3;
    int         sink_stall_lim = 3;

    mirrored_film_negative_map i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int eff_width(input logic [ROW_WIDTH_W-1:0] w);
        if (w == '0) return 1;
        if (int'(w) > MAX_WIDTH) return MAX_WIDTH;
        return int'(w);
    endfunction

    function automatic logic [CHAN_W-1:0] map_level(input logic [CHAN_W-1:0] v,
                                                    input logic [CHAN_W-1:0] lo,
                                                    input logic [CHAN_W-1:0] hi);
        int vi;
        int num;
        vi  = int'(v);
        num = int'(lo) * vi + int'(hi) * (255 - vi);
        return CHAN_W'(num / 255);
    endfunction

    function automatic logic [PIX_W-1:0] pack_pixel(input logic [CHAN_W-1:0] r,
                                                    input logic [CHAN_W-1:0] g,
                                                    input logic [CHAN_W-1:0] b);
        return {b, g, r};
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        return PIX_W'($urandom);
    endfunction

    function automatic logic [CHAN_W-1:0] rand_level();
        return CHAN_W'($urandom);
    endfunction

    function automatic int pick_lim();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            default: return 17;
        endcase
    endfunction

    function automatic logic [CHAN_W-1:0] rail_level();
        return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    endfunction

    // Works out what one accepted beat produces and advances the shadow state.
    task automatic mirror_and_map(input logic cmd, input logic [PIX_W-1:0] pix);
        int         w;
        int         idx;
        logic       last;
        logic [PIX_W-1:0] stored;
        mapped_px_t res;
        w    = eff_width(width_reg);
        last = (col_pos + 1 >= w);
        if (cmd == mfnm_pkg::CMD_DRAIN && !prior_row_ok) begin
            col_pos     = 0;
            row_dropped = 1'b0;
        end else begin
            if (prior_row_ok) begin
                // Past the end of a shrunk row the read falls back to position 0.
                idx    = (col_pos < w) ? (w - 1 - col_pos) : 0;
                stored = row_mem[(wr_bank ? 0 : MAX_WIDTH) + idx];
                res.red     = map_level(stored[7:0],   lo_lvl[0], hi_lvl[0]);
                res.green   = map_level(stored[15:8],  lo_lvl[1], hi_lvl[1]);
                res.blue    = map_level(stored[23:16], lo_lvl[2], hi_lvl[2]);
                res.row_end = last;
                mapped_pixels_due.push_back(res);
            end
            if (cmd == mfnm_pkg::CMD_DRAIN) begin
                row_dropped = 1'b1;
            end else if (col_pos < MAX_WIDTH) begin
                row_mem[(wr_bank ? MAX_WIDTH : 0) + col_pos] = pix;
            end
            if (last) begin
                col_pos = 0;
                if (row_dropped) begin
                    prior_row_ok = 1'b0;
                    row_dropped  = 1'b0;
                end else begin
                    wr_bank      = ~wr_bank;
                    prior_row_ok = 1'b1;
                end
            end else begin
                col_pos++;
            end
        end
    endtask

    task automatic flag_error(input string what);
        error_count++;
        // Only the first MAX_PRINTED mismatches are printed so that a broken block does not flood the log.
        if (error_count <= MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic check_mapped(input logic [PIX_W-1:0] data, input logic last);
        mapped_px_t due;
        if (mapped_pixels_due.size() == 0) begin
            flag_error($sformatf("beat %h tlast %b with nothing pending", data, last));
        end else begin
            due = mapped_pixels_due.pop_front();
            if (data[7:0] !== due.red)
                flag_error($sformatf("red %h, want %h", data[7:0], due.red));
            if (data[15:8] !== due.green)
                flag_error($sformatf("green %h, want %h", data[15:8], due.green));
            if (data[23:16] !== due.blue)
                flag_error($sformatf("blue %h, want %h", data[23:16], due.blue));
            if (last !== due.row_end)
                flag_error($sformatf("tlast %b, want %b", last, due.row_end));
        end
    endtask

    task automatic send_beat(input logic cmd, input logic [PIX_W-1:0] pix);
        int gap;
        gap = int'($urandom_range(0, src_gap_lim));
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        mirror_and_map(cmd, pix);
        beats_sent++;
    endtask

    // A drain with nothing pending gives no beat, so a fixed settle follows the last one.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (mapped_pixels_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            mfnm_pkg::REG_ROW_WIDTH:  width_reg = val;
            mfnm_pkg::REG_RED_LOW:    lo_lvl[0] = val[CHAN_W-1:0];
            mfnm_pkg::REG_RED_HIGH:   hi_lvl[0] = val[CHAN_W-1:0];
            mfnm_pkg::REG_GREEN_LOW:  lo_lvl[1] = val[CHAN_W-1:0];
            mfnm_pkg::REG_GREEN_HIGH: hi_lvl[1] = val[CHAN_W-1:0];
            mfnm_pkg::REG_BLUE_LOW:   lo_lvl[2] = val[CHAN_W-1:0];
            mfnm_pkg::REG_BLUE_HIGH:  hi_lvl[2] = val[CHAN_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // A wider row would read bank entries that were never written, so a pending
    // row is drained out before the width goes up.
    task automatic set_row_width(input logic [ROW_WIDTH_W-1:0] w);
        wait_idle();
        if (eff_width(w) > eff_width(width_reg) && prior_row_ok) begin
            while (prior_row_ok) send_beat(mfnm_pkg::CMD_DRAIN, rand_pixel());
            wait_idle();
        end
        write_reg(mfnm_pkg::REG_ROW_WIDTH, CFG_DATA_W'(w));
    endtask

    task automatic set_levels(input logic [CHAN_W-1:0] red_lo, input logic [CHAN_W-1:0] red_hi,
                              input logic [CHAN_W-1:0] grn_lo, input logic [CHAN_W-1:0] grn_hi,
                              input logic [CHAN_W-1:0] blu_lo, input logic [CHAN_W-1:0] blu_hi);
        wait_idle();
        write_reg(mfnm_pkg::REG_RED_LOW,    CFG_DATA_W'(red_lo));
        write_reg(mfnm_pkg::REG_RED_HIGH,   CFG_DATA_W'(red_hi));
        write_reg(mfnm_pkg::REG_GREEN_LOW,  CFG_DATA_W'(grn_lo));
        write_reg(mfnm_pkg::REG_GREEN_HIGH, CFG_DATA_W'(grn_hi));
        write_reg(mfnm_pkg::REG_BLUE_LOW,   CFG_DATA_W'(blu_lo));
        write_reg(mfnm_pkg::REG_BLUE_HIGH,  CFG_DATA_W'(blu_hi));
    endtask

    task automatic set_random_levels();
        set_levels(rand_level(), rand_level(), rand_level(),
                   rand_level(), rand_level(), rand_level());
    endtask

    // Colour levels left at their reset values, extreme samples, short rows.
    task automatic test_default_levels();
        set_row_width(ROW_WIDTH_W'(2));
        send_beat(mfnm_pkg::CMD_PIXEL, pack_pixel(8'h00, 8'h00, 8'h00));
        send_beat(mfnm_pkg::CMD_PIXEL, pack_pixel(8'hFF, 8'hFF, 8'hFF));
        send_beat(mfnm_pkg::CMD_PIXEL, pack_pixel(8'h55, 8'hAA, 8'h0F));
        send_beat(mfnm_pkg::CMD_PIXEL, pack_pixel(8'hAA, 8'h55, 8'hF0));
        repeat (3) send_beat(mfnm_pkg::CMD_DRAIN, rand_pixel());
    endtask

    // Rail and inverted levels, with a width of zero standing in for one.
    task automatic test_level_extremes();
        set_levels(8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF);
        set_row_width(ROW_WIDTH_W'(0));
        send_beat(mfnm_pkg::CMD_PIXEL, pack_pixel(8'h00, 8'hFF, 8'h00));
        send_beat(mfnm_pkg::CMD_PIXEL, pack_pixel(8'hFF, 8'h00, 8'hFF));
        send_beat(mfnm_pkg::CMD_PIXEL, pack_pixel(8'h80, 8'h7F, 8'h01));
        send_beat(mfnm_pkg::CMD_DRAIN, rand_pixel());
    endtask

    // A drain inside a row with a pending row drops the row in progress; a drain
    // with nothing pending only restarts the row.
    task automatic test_drain_mid_row();
        set_random_levels();
        set_row_width(ROW_WIDTH_W'(3));
        repeat (3) send_beat(mfnm_pkg::CMD_PIXEL, rand_pixel());
        send_beat(mfnm_pkg::CMD_PIXEL, rand_pixel());
        send_beat(mfnm_pkg::CMD_DRAIN, rand_pixel());
        send_beat(mfnm_pkg::CMD_PIXEL, rand_pixel());
        send_beat(mfnm_pkg::CMD_PIXEL, rand_pixel());
        send_beat(mfnm_pkg::CMD_DRAIN, rand_pixel());
    endtask

    // Width shrinks below the current column, and the levels change between the
    // write and the read of the same pixels.
    task automatic test_shrink_mid_row();
        set_row_width(ROW_WIDTH_W'(4));
        repeat (4) send_beat(mfnm_pkg::CMD_PIXEL, rand_pixel());
        repeat (3) send_beat(mfnm_pkg::CMD_PIXEL, rand_pixel());
        set_random_levels();
        set_row_width(ROW_WIDTH_W'(2));
        send_beat(mfnm_pkg::CMD_PIXEL, rand_pixel());
        repeat (3) send_beat(mfnm_pkg::CMD_DRAIN, rand_pixel());
    endtask

    // One row at the largest width, with a register value above MAX_WIDTH.
    task automatic test_widest_row();
        src_gap_lim    = 2;
        sink_stall_lim = 2;
        set_row_width(ROW_WIDTH_W'($urandom_range(MAX_WIDTH + 1, 2**ROW_WIDTH_W - 1)));
        repeat (MAX_WIDTH) send_beat(mfnm_pkg::CMD_PIXEL, rand_pixel());
        repeat (MAX_WIDTH + 1) send_beat(mfnm_pkg::CMD_DRAIN, rand_pixel());
    endtask

    // Mostly well-formed rows of random pixels, with stray drains and the odd full drain.
    task automatic test_random_stream();
        int pick;
        int w;
        int n_items;
        while (beats_sent < ITEM_TARGET) begin
            src_gap_lim    = pick_lim();
            sink_stall_lim = pick_lim();
            pick = int'($urandom_range(0, 15));
            if (pick == 0) w = 0;
            else if (pick < 3) w = int'($urandom_range(13, 64));
            else w = int'($urandom_range(1, 12));
            set_row_width(ROW_WIDTH_W'(w));
            if ($urandom_range(0, 3) == 0)
                set_levels(rail_level(), rail_level(), rail_level(),
                           rail_level(), rail_level(), rail_level());
            else
                set_random_levels();
            n_items = int'($urandom_range(10, 80));
            repeat (n_items) begin
                if ($urandom_range(0, 24) == 0) send_beat(mfnm_pkg::CMD_DRAIN, rand_pixel());
                else send_beat(mfnm_pkg::CMD_PIXEL, rand_pixel());
            end
            if ($urandom_range(0, 7) == 0)
                repeat (eff_width(width_reg) + 1) send_beat(mfnm_pkg::CMD_DRAIN, rand_pixel());
        end
    endtask

    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = int'($urandom_range(0, sink_stall_lim));
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            check_mapped(m_tdata, m_tlast);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("mirrored_film_negative_map_tb: done, errors");
            $finish;
        end
    end

    initial begin
        col_pos      = 0;
        wr_bank      = 1'b0;
        prior_row_ok = 1'b0;
        row_dropped  = 1'b0;
        width_reg    = mfnm_pkg::RST_ROW_WIDTH;
        lo_lvl[0]    = mfnm_pkg::RST_RED_LOW;
        hi_lvl[0]    = mfnm_pkg::RST_RED_HIGH;
        lo_lvl[1]    = mfnm_pkg::RST_GREEN_LOW;
        hi_lvl[1]    = mfnm_pkg::RST_GREEN_HIGH;
        lo_lvl[2]    = mfnm_pkg::RST_BLUE_LOW;
        hi_lvl[2]    = mfnm_pkg::RST_BLUE_HIGH;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_levels();
        test_level_extremes();
        test_drain_mid_row();
        test_shrink_mid_row();
        test_widest_row();
        test_random_stream();
        wait_idle();

        if (error_count == 0) begin
            $display("mirrored_film_negative_map_tb: done, clean");
        end else begin
            $display("mirrored_film_negative_map_tb: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/mfnm_pkg.sv
src/mirrored_film_negative_map.sv
src/mfnm_checker.sv
sim/mirrored_film_negative_map_tb.sv
